// ----- design/ufrs_pkg.sv -----
// ----------------------------------------------------------------------------
// Update fetch retry scheduler package
// Shared constants, action codes and request/result structs.
// ----------------------------------------------------------------------------
`default_nettype none

package ufrs_pkg;

  // Default width of the nudge tag.
  localparam int TAG_BITS_DEF = 16;

  // Fixed field widths.
  localparam int BV_BITS     = 32;
  localparam int TICK_BITS   = 32;
  localparam int STATUS_BITS = 10;

  // Reset value of the cooldown register.
  localparam logic [TICK_BITS-1:0] COOLDOWN_RST = 32'd60000;

  // Command codes carried in in_tuser.
  localparam logic CMD_NUDGE   = 1'b0;
  localparam logic CMD_SERVICE = 1'b1;

  // HTTP status codes of interest.
  localparam logic [STATUS_BITS-1:0] HTTP_OK        = 10'd200;
  localparam logic [STATUS_BITS-1:0] HTTP_BAD_REQ   = 10'd400;
  localparam logic [STATUS_BITS-1:0] HTTP_UNAUTH    = 10'd401;
  localparam logic [STATUS_BITS-1:0] HTTP_NOT_FOUND = 10'd404;
  localparam logic [STATUS_BITS-1:0] HTTP_CONFLICT  = 10'd409;

  // Action reported with each result.
  typedef enum logic [2:0] {
    ACT_NONE        = 3'd0,
    ACT_ACK         = 3'd1,
    ACT_STARTED     = 3'd2,
    ACT_START_FAIL  = 3'd3,
    ACT_APPLIED     = 3'd4,
    ACT_RETRY_LATER = 3'd5,
    ACT_RETRY_NOW   = 3'd6,
    ACT_DROPPED     = 3'd7
  } ufrs_act_t;

  // One request, without the tag (its width is a parameter).
  typedef struct packed {
    logic                   command;
    logic [BV_BITS-1:0]     nudge_ver;
    logic [BV_BITS-1:0]     dev_ver;
    logic                   fetch_busy;
    logic [TICK_BITS-1:0]   now_ticks;
    logic                   start_ok;
    logic                   fetch_done;
    logic [STATUS_BITS-1:0] resp_code;
    logic                   verify_ok;
    logic                   apply_ok;
  } ufrs_req_t;

  // One result, without the tag.
  typedef struct packed {
    ufrs_act_t          action;
    logic [BV_BITS-1:0] result_bv;
    logic               pending_flag;
    logic               fetching_flag;
  } ufrs_res_t;

endpackage

`default_nettype wire

// ----- design/ufrs_in_stage.sv -----
// ----------------------------------------------------------------------------
// Update fetch retry scheduler input stage
// Holds one accepted request until the decision logic consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ufrs_in_stage #(
  parameter int TAG_BITS = ufrs_pkg::TAG_BITS_DEF
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  ufrs_pkg::ufrs_req_t      in_req,
  input  wire  [TAG_BITS-1:0]      in_tag,
  input  wire                      take,
  output logic                     s1_valid,
  output ufrs_pkg::ufrs_req_t      s1_req,
  output logic [TAG_BITS-1:0]      s1_tag
);
  import ufrs_pkg::*;

  logic                valid_r;
  logic                valid_nxt;
  ufrs_req_t           req_r;
  logic [TAG_BITS-1:0] tag_r;
  logic                load;

  // Room when empty or when the held request leaves in this cycle.
  assign in_ready  = !valid_r || take;
  assign load      = in_valid && in_ready;
  assign valid_nxt = load || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Request payload.
  always_ff @(posedge clk) begin
    if (load) begin
      req_r <= in_req;
      tag_r <= in_tag;
    end
  end

  assign s1_valid = valid_r;
  assign s1_req   = req_r;
  assign s1_tag   = tag_r;

endmodule

`default_nettype wire

// ----- design/ufrs_core.sv -----
// ----------------------------------------------------------------------------
// Update fetch retry scheduler decision core
// Holds the scheduler state and decides one action per request.
// ----------------------------------------------------------------------------
`default_nettype none

module ufrs_core #(
  parameter int TAG_BITS = ufrs_pkg::TAG_BITS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 cfg_wr_en,
  input  wire  [ufrs_pkg::TICK_BITS-1:0]      cfg_wr_data,
  input  wire                                 fire,
  input  ufrs_pkg::ufrs_req_t                 req,
  input  wire  [TAG_BITS-1:0]                 req_tag,
  output ufrs_pkg::ufrs_res_t                 res,
  output logic [TAG_BITS-1:0]                 res_tag
);
  import ufrs_pkg::*;

  // Control state.
  logic                 fetching_r, fetching_nxt;
  logic                 pend_r, pend_nxt;
  logic                 armed_r, armed_nxt;
  logic                 tried_r, tried_nxt;
  logic [TICK_BITS-1:0] cooldown_r;

  // Payload state.
  logic [BV_BITS-1:0]   pend_bv_r, pend_bv_nxt;
  logic [TAG_BITS-1:0]  pend_tag_r, pend_tag_nxt;
  logic [BV_BITS-1:0]   fly_bv_r, fly_bv_nxt;
  logic [TAG_BITS-1:0]  fly_tag_r, fly_tag_nxt;
  logic [TICK_BITS-1:0] last_r, last_nxt;

  logic [TICK_BITS-1:0] elapsed;
  logic                 due;
  logic                 is_drop;
  ufrs_act_t            act;
  logic [BV_BITS-1:0]   rbv;
  logic [TAG_BITS-1:0]  rtag;

  // Cooldown check with wrapping time.
  assign elapsed = req.now_ticks - last_r;
  assign due     = armed_r || !tried_r || (elapsed >= cooldown_r);
  assign is_drop = (req.resp_code == HTTP_BAD_REQ) || (req.resp_code == HTTP_UNAUTH) ||
                   (req.resp_code == HTTP_NOT_FOUND);

  // Next state and action for the current request.
  always_comb begin
    fetching_nxt = fetching_r;
    pend_nxt     = pend_r;
    armed_nxt    = armed_r;
    tried_nxt    = tried_r;
    pend_bv_nxt  = pend_bv_r;
    pend_tag_nxt = pend_tag_r;
    fly_bv_nxt   = fly_bv_r;
    fly_tag_nxt  = fly_tag_r;
    last_nxt     = last_r;
    act          = ACT_NONE;
    rbv          = '0;
    rtag         = '0;
    if (req.command == CMD_NUDGE) begin
      if (req.nudge_ver <= req.dev_ver) begin
        act  = ACT_ACK;
        rbv  = req.nudge_ver;
        rtag = req_tag;
      end else begin
        // Newest nudge takes the pending slot.
        pend_nxt     = 1'b1;
        pend_bv_nxt  = req.nudge_ver;
        pend_tag_nxt = req_tag;
      end
    end else if (!fetching_r) begin
      if (pend_r) begin
        if (pend_bv_r <= req.dev_ver) begin
          pend_nxt = 1'b0;
          act      = ACT_ACK;
          rbv      = pend_bv_r;
          rtag     = pend_tag_r;
        end else if (!req.fetch_busy && due) begin
          // An attempt counts even when the launch fails.
          pend_nxt  = 1'b0;
          last_nxt  = req.now_ticks;
          tried_nxt = 1'b1;
          rbv       = pend_bv_r;
          rtag      = pend_tag_r;
          if (req.start_ok) begin
            fly_bv_nxt   = pend_bv_r;
            fly_tag_nxt  = pend_tag_r;
            armed_nxt    = 1'b0;
            fetching_nxt = 1'b1;
            act          = ACT_STARTED;
          end else begin
            act = ACT_START_FAIL;
          end
        end
      end
    end else if (req.fetch_done) begin
      rbv          = fly_bv_r;
      rtag         = fly_tag_r;
      fetching_nxt = 1'b0;
      priority if (req.resp_code == HTTP_OK && req.verify_ok && req.apply_ok) begin
        act = ACT_APPLIED;
      end else if (req.resp_code == HTTP_CONFLICT) begin
        act       = ACT_RETRY_NOW;
        armed_nxt = 1'b1;
      end else if (is_drop) begin
        act = ACT_DROPPED;
      end else begin
        act = ACT_RETRY_LATER;
      end
      // Re-queue only when no newer nudge took the slot.
      if ((act == ACT_RETRY_NOW || act == ACT_RETRY_LATER) && !pend_r) begin
        pend_nxt     = 1'b1;
        pend_bv_nxt  = fly_bv_r;
        pend_tag_nxt = fly_tag_r;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fetching_r <= 1'b0;
      pend_r     <= 1'b0;
      armed_r    <= 1'b0;
      tried_r    <= 1'b0;
      cooldown_r <= COOLDOWN_RST;
    end else begin
      if (fire) begin
        fetching_r <= fetching_nxt;
        pend_r     <= pend_nxt;
        armed_r    <= armed_nxt;
        tried_r    <= tried_nxt;
      end
      if (cfg_wr_en) begin
        cooldown_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers; each is read only after it was written.
  always_ff @(posedge clk) begin
    if (fire) begin
      pend_bv_r  <= pend_bv_nxt;
      pend_tag_r <= pend_tag_nxt;
      fly_bv_r   <= fly_bv_nxt;
      fly_tag_r  <= fly_tag_nxt;
      last_r     <= last_nxt;
    end
  end

  assign res.action        = act;
  assign res.result_bv     = rbv;
  assign res.pending_flag  = pend_nxt;
  assign res.fetching_flag = fetching_nxt;
  assign res_tag           = rtag;

endmodule

`default_nettype wire

// ----- design/ufrs_out_stage.sv -----
// ----------------------------------------------------------------------------
// Update fetch retry scheduler output stage
// Result register that holds a result until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ufrs_out_stage #(
  parameter int TAG_BITS = ufrs_pkg::TAG_BITS_DEF
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      load,
  input  ufrs_pkg::ufrs_res_t      res,
  input  wire  [TAG_BITS-1:0]      res_tag,
  output logic                     free,
  output logic                     out_valid,
  input  wire                      out_ready,
  output ufrs_pkg::ufrs_res_t      out_res,
  output logic [TAG_BITS-1:0]      out_tag
);
  import ufrs_pkg::*;

  logic                valid_r;
  logic                valid_nxt;
  ufrs_res_t           res_r;
  logic [TAG_BITS-1:0] tag_r;

  // A new result may enter when empty or when the held one leaves.
  assign free      = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
      tag_r <= res_tag;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;
  assign out_tag   = tag_r;

endmodule

`default_nettype wire

// ----- design/update_fetch_retry_scheduler.sv -----
// ----------------------------------------------------------------------------
// Update fetch retry scheduler
// Schedules fetches of a versioned update after version nudges.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the in_ stream: in_tuser carries the command (nudge or
//   service step), in_tdata the nudge, the stored version, the fetch guard,
//   the time and the result of a finished fetch. Every request gives exactly
//   one result on the out_ stream: out_tuser carries the action, out_tdata
//   the tag and version it concerns and the pending and fetching flags.
//   The cooldown register is written through cfg_wr_en/cfg_wr_data; the user must
//   write it only while no request is in flight, which the block does not enforce.
//   A request is accepted into the input register, then decided and
//   captured in the result register. Throughput is one request per cycle
//   while the receiver does not stall, set by the single decision stage
//   that reads and updates the scheduler state in the same cycle.
//   When the receiver stalls, the result register holds its result, the
//   input register still takes one more request, and in_tready then drops.
//   Reset (synchronous, rst_n low) empties both registers, clears the
//   pending slot, the fetching phase and the retry marks, and loads the
//   cooldown with its default of 60000 ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module update_fetch_retry_scheduler #(
  parameter int  TAG_BITS   = ufrs_pkg::TAG_BITS_DEF,
  localparam int IN_BITS    = 111 + TAG_BITS,
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS   = 34 + TAG_BITS,
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire                       clk,
  input  wire                       rst_n,
  // Request stream.
  input  wire                       in_tvalid,
  output logic                      in_tready,
  // tdata: nudge_ver, nudge_tag, dev_ver, fetch_busy, now_ticks, start_ok,
  //        fetch_done, resp_code, verify_ok, apply_ok (lowest bit first)
  input  wire  [IN_TDATA_W-1:0]     in_tdata,
  // tuser: command
  input  wire  [0:0]                in_tuser,
  // Result stream.
  output logic                      out_tvalid,
  input  wire                       out_tready,
  // tdata: result_tag, result_bv, pending_flag, fetching_flag
  output logic [OUT_TDATA_W-1:0]    out_tdata,
  // tuser: action
  output logic [2:0]                out_tuser,
  // Cooldown register.
  input  wire                       cfg_wr_en,
  input  wire  [31:0]               cfg_wr_data
);
  import ufrs_pkg::*;

  ufrs_req_t           in_req;
  logic [TAG_BITS-1:0] in_tag;
  logic                s1_valid;
  ufrs_req_t           s1_req;
  logic [TAG_BITS-1:0] s1_tag;
  logic                out_free;
  logic                fire;
  ufrs_res_t           core_res;
  logic [TAG_BITS-1:0] core_tag;
  ufrs_res_t           out_res;
  logic [TAG_BITS-1:0] out_tag;

  // Unpack the request.
  always_comb begin
    in_req.command    = in_tuser[0];
    in_req.nudge_ver  = in_tdata[31:0];
    in_req.dev_ver    = in_tdata[TAG_BITS+32 +: BV_BITS];
    in_req.fetch_busy = in_tdata[TAG_BITS+64];
    in_req.now_ticks  = in_tdata[TAG_BITS+65 +: TICK_BITS];
    in_req.start_ok   = in_tdata[TAG_BITS+97];
    in_req.fetch_done = in_tdata[TAG_BITS+98];
    in_req.resp_code  = in_tdata[TAG_BITS+99 +: STATUS_BITS];
    in_req.verify_ok  = in_tdata[TAG_BITS+109];
    in_req.apply_ok   = in_tdata[TAG_BITS+110];
    in_tag            = in_tdata[32 +: TAG_BITS];
  end

  assign fire = s1_valid && out_free;

  ufrs_in_stage #(.TAG_BITS(TAG_BITS)) u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_req   (in_req),
    .in_tag   (in_tag),
    .take     (out_free),
    .s1_valid (s1_valid),
    .s1_req   (s1_req),
    .s1_tag   (s1_tag)
  );

  ufrs_core #(.TAG_BITS(TAG_BITS)) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fire        (fire),
    .req         (s1_req),
    .req_tag     (s1_tag),
    .res         (core_res),
    .res_tag     (core_tag)
  );

  ufrs_out_stage #(.TAG_BITS(TAG_BITS)) u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .res       (core_res),
    .res_tag   (core_tag),
    .free      (out_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res),
    .out_tag   (out_tag)
  );

  // Pack the result.
  always_comb begin
    out_tdata                          = '0;
    out_tdata[TAG_BITS-1:0]            = out_tag;
    out_tdata[TAG_BITS +: BV_BITS]     = out_res.result_bv;
    out_tdata[TAG_BITS+32]             = out_res.pending_flag;
    out_tdata[TAG_BITS+33]             = out_res.fetching_flag;
    out_tuser                          = out_res.action;
  end

endmodule

`default_nettype wire

// ----- design/ufrs_checker.sv -----
// ----------------------------------------------------------------------------
// Update fetch retry scheduler checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ufrs_checker #(
  parameter int  TAG_BITS    = ufrs_pkg::TAG_BITS_DEF,
  localparam int OUT_BITS    = 34 + TAG_BITS,
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
  input wire                   clk,
  input wire                   rst_n,
  input wire                   out_tvalid,
  input wire                   out_tready,
  input wire [OUT_TDATA_W-1:0] out_tdata,
  input wire [2:0]             out_tuser
);
  import ufrs_pkg::*;

  // A stalled result holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Nothing is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result offered right after reset");

  // An empty action names no nudge.
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ACT_NONE |-> out_tdata[TAG_BITS+31:0] == '0)
    else $error("empty action carries a tag or version");

  // A started fetch leaves the block fetching; a finished fetch leaves it idle.
  a_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      (out_tuser == ACT_STARTED) == out_tdata[TAG_BITS+33] ||
      !(out_tuser == ACT_STARTED || out_tuser == ACT_APPLIED ||
        out_tuser == ACT_RETRY_LATER || out_tuser == ACT_RETRY_NOW ||
        out_tuser == ACT_DROPPED))
    else $error("fetching flag disagrees with action");

  // A retry always leaves a nudge pending.
  a_retry_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ACT_RETRY_LATER || out_tuser == ACT_RETRY_NOW) |->
      out_tdata[TAG_BITS+32])
    else $error("retry without pending nudge");

endmodule

bind update_fetch_retry_scheduler ufrs_checker #(.TAG_BITS(TAG_BITS)) u_ufrs_checker (.*);

`default_nettype wire

// ----- verif/ufrs_checker.sv -----
// ----------------------------------------------------------------------------
// Update fetch retry scheduler checker
// Watches the request, result and cooldown ports of the scheduler, keeps its
// own copy of the scheduling state, predicts one result per accepted request
// and compares every accepted result field by field with the oldest
// prediction. It hands the failure count and the number of results still
// awaited to the testbench top.
// ----------------------------------------------------------------------------
module ufrs_tb_checker (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  input  wire         in_tready,
  input  wire [127:0] in_tdata,
  input  wire [0:0]   in_tuser,
  input  wire         out_tvalid,
  input  wire         out_tready,
  input  wire [55:0]  out_tdata,
  input  wire [2:0]   out_tuser,
  input  wire         cfg_wr_en,
  input  wire [31:0]  cfg_wr_data,
  output int          fail_count,
  output int          awaited
);
  import ufrs_pkg::*;

  // Request layout on in_tdata, highest field first.
  typedef struct packed {
    logic                   pad;
    logic                   apply_ok;
    logic                   verify_ok;
    logic [STATUS_BITS-1:0] resp_code;
    logic                   fetch_done;
    logic                   start_ok;
    logic [TICK_BITS-1:0]   now_ticks;
    logic                   fetch_busy;
    logic [BV_BITS-1:0]     dev_ver;
    logic [15:0]            nudge_tag;
    logic [BV_BITS-1:0]     nudge_ver;
  } req_bits_t;

  // What one request is expected to produce.
  typedef struct {
    ufrs_act_t          action;
    logic [15:0]        tag;
    logic [BV_BITS-1:0] bv;
    logic               pending;
    logic               fetching;
  } sched_outcome_t;

  sched_outcome_t outcome_q[$];

  // Scheduler state as the checker sees it.
  logic [TICK_BITS-1:0] cooldown;
  logic                 fetching;
  logic                 have_pending;
  logic [BV_BITS-1:0]   pend_bv;
  logic [15:0]          pend_tag;
  logic [BV_BITS-1:0]   flight_bv;
  logic [15:0]          flight_tag;
  logic                 retry_armed;
  logic                 attempted;
  logic [TICK_BITS-1:0] last_try;

  initial begin
    fail_count = 0;
    awaited    = 0;
  end

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 40) begin
      $display("%0t ufrs_tb_checker: %s", $time, msg);
    end
  endtask

  task automatic clear_schedule();
    cooldown     = COOLDOWN_RST;
    fetching     = 1'b0;
    have_pending = 1'b0;
    pend_bv      = '0;
    pend_tag     = '0;
    flight_bv    = '0;
    flight_tag   = '0;
    retry_armed  = 1'b0;
    attempted    = 1'b0;
    last_try     = '0;
  endtask

  // A finished nudge goes back to the slot only if no newer one took it.
  task automatic requeue_flight();
    if (!have_pending) begin
      have_pending = 1'b1;
      pend_bv      = flight_bv;
      pend_tag     = flight_tag;
    end
  endtask

  // Applies one request to the state and returns the result it causes.
  task automatic predict_schedule(input logic cmd, input req_bits_t r,
                                  output sched_outcome_t o);
    logic [TICK_BITS-1:0] since_try;
    logic                 due;
    o.action = ACT_NONE;
    o.tag    = '0;
    o.bv     = '0;
    if (cmd == CMD_NUDGE) begin
      if (r.nudge_ver <= r.dev_ver) begin
        o.action = ACT_ACK;
        o.tag    = r.nudge_tag;
        o.bv     = r.nudge_ver;
      end else begin
        have_pending = 1'b1;
        pend_bv      = r.nudge_ver;
        pend_tag     = r.nudge_tag;
      end
    end else if (!fetching) begin
      if (have_pending) begin
        since_try = r.now_ticks - last_try;
        due = retry_armed || !attempted || (since_try >= cooldown);
        // Staleness wins over the guard and the cooldown.
        if (pend_bv <= r.dev_ver) begin
          have_pending = 1'b0;
          o.action     = ACT_ACK;
          o.tag        = pend_tag;
          o.bv         = pend_bv;
        end else if (!r.fetch_busy && due) begin
          have_pending = 1'b0;
          last_try     = r.now_ticks;
          attempted    = 1'b1;
          o.tag        = pend_tag;
          o.bv         = pend_bv;
          if (r.start_ok) begin
            flight_bv   = pend_bv;
            flight_tag  = pend_tag;
            retry_armed = 1'b0;
            fetching    = 1'b1;
            o.action    = ACT_STARTED;
          end else begin
            o.action = ACT_START_FAIL;
          end
        end
      end
    end else if (r.fetch_done) begin
      o.tag = flight_tag;
      o.bv  = flight_bv;
      if (r.resp_code == HTTP_OK && r.verify_ok && r.apply_ok) begin
        o.action = ACT_APPLIED;
      end else if (r.resp_code == HTTP_CONFLICT) begin
        retry_armed = 1'b1;
        requeue_flight();
        o.action = ACT_RETRY_NOW;
      end else if (r.resp_code == HTTP_BAD_REQ || r.resp_code == HTTP_UNAUTH ||
                   r.resp_code == HTTP_NOT_FOUND) begin
        o.action = ACT_DROPPED;
      end else begin
        requeue_flight();
        o.action = ACT_RETRY_LATER;
      end
      fetching = 1'b0;
    end
    o.pending  = have_pending;
    o.fetching = fetching;
  endtask

  // Results are compared before new requests are predicted, so a stray
  // result never meets the prediction of a request taken at the same edge.
  always @(posedge clk) begin
    sched_outcome_t want;
    sched_outcome_t next;
    if (!rst_n) begin
      clear_schedule();
      outcome_q.delete();
    end else begin
      if (cfg_wr_en) begin
        cooldown = cfg_wr_data;
      end
      if (out_tvalid && out_tready) begin
        if (outcome_q.size() == 0) begin
          report_mismatch($sformatf("result with no request waiting, action %0d",
                                    out_tuser));
        end else begin
          want = outcome_q.pop_front();
          if (out_tuser !== want.action) begin
            report_mismatch($sformatf("action got %0d expected %0d",
                                      out_tuser, want.action));
          end
          if (out_tdata[15:0] !== want.tag) begin
            report_mismatch($sformatf("result_tag got %h expected %h",
                                      out_tdata[15:0], want.tag));
          end
          if (out_tdata[47:16] !== want.bv) begin
            report_mismatch($sformatf("result_bv got %h expected %h",
                                      out_tdata[47:16], want.bv));
          end
          if (out_tdata[48] !== want.pending) begin
            report_mismatch($sformatf("pending_flag got %b expected %b",
                                      out_tdata[48], want.pending));
          end
          if (out_tdata[49] !== want.fetching) begin
            report_mismatch($sformatf("fetching_flag got %b expected %b",
                                      out_tdata[49], want.fetching));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        predict_schedule(in_tuser[0], req_bits_t'(in_tdata), next);
        outcome_q.push_back(next);
      end
    end
    awaited <= outcome_q.size();
  end

endmodule

// ----- verif/tb_update_fetch_retry_scheduler.sv -----
// ----------------------------------------------------------------------------
// Update fetch retry scheduler testbench
// Drives nudges and service steps into the scheduler: a directed sequence
// through every action and corner, then random nudge/launch/finish episodes
// under several cooldown settings, with random gaps on both streams. The
// checker beside the block predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_update_fetch_retry_scheduler;
  import ufrs_pkg::*;

  localparam int IN_W        = 128;
  localparam int OUT_W       = 56;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 325;

  // Request layout on in_tdata, highest field first.
  typedef struct packed {
    logic                   pad;
    logic                   apply_ok;
    logic                   verify_ok;
    logic [STATUS_BITS-1:0] resp_code;
    logic                   fetch_done;
    logic                   start_ok;
    logic [TICK_BITS-1:0]   now_ticks;
    logic                   fetch_busy;
    logic [BV_BITS-1:0]     dev_ver;
    logic [15:0]            nudge_tag;
    logic [BV_BITS-1:0]     nudge_ver;
  } req_bits_t;

  logic             clk;
  logic             rst_n       = 1'b0;
  logic             in_tvalid   = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata    = '0;
  logic [0:0]       in_tuser    = '0;
  logic             out_tvalid;
  logic             out_tready  = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic [2:0]       out_tuser;
  logic             cfg_wr_en   = 1'b0;
  logic [31:0]      cfg_wr_data = '0;

  int          fail_count;
  int          awaited;
  int          items_sent   = 0;
  int          quiet_cycles = 0;
  logic        calm         = 1'b0;
  logic [31:0] tick         = '0;
  logic [31:0] dev_bv       = '0;
  logic [31:0] cooldown_now = COOLDOWN_RST;

  update_fetch_retry_scheduler u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  ufrs_tb_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .fail_count (fail_count),
    .awaited    (awaited)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Idle length: mostly none, some short, a few long; none in calm stretches.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Random request bits; fields that a command ignores keep random values.
  function automatic req_bits_t random_bits();
    req_bits_t b;
    b           = {$urandom, $urandom, $urandom, $urandom};
    b.pad       = 1'b0;
    b.resp_code = 10'($urandom_range(0, 999));
    return b;
  endfunction

  function automatic req_bits_t nudge_bits(input logic [31:0] bv, input logic [15:0] tag,
                                           input logic [31:0] sbv);
    req_bits_t b;
    b           = random_bits();
    b.nudge_ver = bv;
    b.nudge_tag = tag;
    b.dev_ver   = sbv;
    return b;
  endfunction

  function automatic req_bits_t service_bits(input logic [31:0] sbv, input logic busy,
                                             input logic [31:0] now, input logic sok,
                                             input logic done, input logic [9:0] status,
                                             input logic vok, input logic aok);
    req_bits_t b;
    b            = random_bits();
    b.dev_ver    = sbv;
    b.fetch_busy = busy;
    b.now_ticks  = now;
    b.start_ok   = sok;
    b.fetch_done = done;
    b.resp_code  = status;
    b.verify_ok  = vok;
    b.apply_ok   = aok;
    return b;
  endfunction

  // One request on the input stream, held until the block takes it.
  task automatic send_request(input logic cmd, input req_bits_t bits);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= bits;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // Holds the sender until every awaited result has come out.
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (awaited != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cooldown(input logic [31:0] value);
    wait_drain();
    cfg_wr_data  <= value;
    cfg_wr_en    <= 1'b1;
    cooldown_now = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Moves time on: a little, about one cooldown, or anywhere.
  task automatic advance_clock();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      tick = tick + $urandom_range(0, 3);
    end else if (r < 8) begin
      tick = tick + cooldown_now + $urandom_range(0, 4) - 2;
    end else begin
      tick = $urandom;
    end
  endtask

  function automatic logic [9:0] pick_status();
    int r;
    r = $urandom_range(0, 19);
    if (r < 8) return HTTP_OK;
    if (r < 11) return HTTP_CONFLICT;
    if (r == 11) return HTTP_BAD_REQ;
    if (r == 12) return HTTP_UNAUTH;
    if (r == 13) return HTTP_NOT_FOUND;
    if (r < 16) return 10'd0;
    if (r == 16) return 10'd999;
    return 10'($urandom_range(0, 999));
  endfunction

  // One random episode: mostly nudges, launch attempts and a finished fetch,
  // sometimes a few unrelated requests.
  task automatic random_episode();
    int          n;
    logic [31:0] bv;
    logic [15:0] tag;
    logic [9:0]  status;
    if ($urandom_range(0, 19) == 0) begin
      calm = !calm;
    end
    if ($urandom_range(0, 49) == 0) begin
      wait_drain();
    end
    if ($urandom_range(0, 9) == 0) begin
      dev_bv = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFF0 + $urandom_range(0, 15) : $urandom;
    end
    if ($urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 3);
      repeat (n) send_request(1'($urandom_range(0, 1)), random_bits());
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) begin
        bv  = ($urandom_range(0, 5) == 0) ? dev_bv - $urandom_range(0, 3)
                                          : dev_bv + $urandom_range(1, 4);
        tag = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom_range(0, 65535));
        send_request(CMD_NUDGE, nudge_bits(bv, tag, dev_bv));
      end
      // The device sometimes catches up, which makes the pending nudge stale.
      if ($urandom_range(0, 5) == 0) begin
        dev_bv = dev_bv + $urandom_range(1, 6);
      end
      n = $urandom_range(1, 3);
      repeat (n) begin
        advance_clock();
        send_request(CMD_SERVICE,
                     service_bits(dev_bv, $urandom_range(0, 4) == 0, tick,
                                  $urandom_range(0, 7) != 0, 1'b0,
                                  10'($urandom_range(0, 999)), 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1))));
      end
      advance_clock();
      status = pick_status();
      send_request(CMD_SERVICE,
                   service_bits(dev_bv, $urandom_range(0, 4) == 0, tick,
                                1'($urandom_range(0, 1)), 1'b1, status,
                                $urandom_range(0, 7) != 0, $urandom_range(0, 7) != 0));
    end
  endtask

  // Result side: ready with random stalls.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        stall_left = idle_gap();
      end
    end
  end

  // Watchdog on cycles in which neither stream moves a request or result.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_update_fetch_retry_scheduler: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int phase_goal;
    logic [31:0] phase_cooldown [4];
    phase_cooldown[0] = 32'd1;
    phase_cooldown[1] = $urandom_range(2, 64);
    phase_cooldown[2] = 32'hFFFF_FFFF;
    phase_cooldown[3] = $urandom_range(1000, 200000);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset cooldown of 60000 ticks.
    // An older-or-equal nudge with an empty id is acknowledged at once.
    send_request(CMD_NUDGE, nudge_bits(32'd0, 16'd0, 32'd0));
    send_request(CMD_NUDGE, nudge_bits(32'hFFFF_FFFF, 16'hFFFF, 32'd0));
    // Guard held: nothing starts.
    send_request(CMD_SERVICE,
                 service_bits(32'd0, 1'b1, 32'd5, 1'b1, 1'b0, 10'd0, 1'b1, 1'b1));
    // First attempt is always due; the launch fails and the nudge is lost.
    send_request(CMD_SERVICE,
                 service_bits(32'd0, 1'b0, 32'd5, 1'b0, 1'b0, 10'd0, 1'b1, 1'b1));
    send_request(CMD_NUDGE, nudge_bits(32'd10, 16'd1, 32'd5));
    // One tick after the attempt: cooldown not elapsed.
    send_request(CMD_SERVICE,
                 service_bits(32'd5, 1'b0, 32'd6, 1'b1, 1'b0, 10'd0, 1'b1, 1'b1));
    // Exactly one cooldown later: fetch starts.
    send_request(CMD_SERVICE,
                 service_bits(32'd5, 1'b0, 32'd60005, 1'b1, 1'b0, 10'd0, 1'b1, 1'b1));
    // A nudge during the fetch fills the slot and leaves the fetch alone.
    send_request(CMD_NUDGE, nudge_bits(32'd20, 16'd2, 32'd5));
    send_request(CMD_SERVICE,
                 service_bits(32'd5, 1'b0, 32'd60005, 1'b1, 1'b0, HTTP_OK, 1'b1, 1'b1));
    // Conflict: retry armed, but the newer nudge keeps the slot.
    send_request(CMD_SERVICE,
                 service_bits(32'd5, 1'b0, 32'd60005, 1'b1, 1'b1, HTTP_CONFLICT,
                              1'b1, 1'b1));
    // Armed retry is due at once; failed launch leaves it armed.
    send_request(CMD_SERVICE,
                 service_bits(32'd5, 1'b0, 32'd60006, 1'b0, 1'b0, 10'd0, 1'b1, 1'b1));
    send_request(CMD_NUDGE, nudge_bits(32'd30, 16'd3, 32'd5));
    send_request(CMD_SERVICE,
                 service_bits(32'd5, 1'b0, 32'd60007, 1'b1, 1'b0, 10'd0, 1'b1, 1'b1));
    // Status 200 without verification goes back to the slot.
    send_request(CMD_SERVICE,
                 service_bits(32'd5, 1'b0, 32'd60007, 1'b1, 1'b1, HTTP_OK, 1'b0, 1'b1));
    // Staleness is checked before the guard.
    send_request(CMD_SERVICE,
                 service_bits(32'd30, 1'b1, 32'd60007, 1'b1, 1'b0, 10'd0, 1'b1, 1'b1));
    send_request(CMD_NUDGE, nudge_bits(32'd40, 16'd4, 32'd0));
    send_request(CMD_SERVICE,
                 service_bits(32'd0, 1'b0, 32'd120007, 1'b1, 1'b0, 10'd0, 1'b1, 1'b1));
    send_request(CMD_SERVICE,
                 service_bits(32'd0, 1'b0, 32'd120007, 1'b1, 1'b1, HTTP_OK, 1'b1, 1'b1));
    send_request(CMD_NUDGE, nudge_bits(32'd41, 16'd4, 32'd0));
    // Time one tick behind the last attempt wraps to the largest distance.
    send_request(CMD_SERVICE,
                 service_bits(32'd0, 1'b0, 32'd120006, 1'b1, 1'b0, 10'd0, 1'b1, 1'b1));
    send_request(CMD_SERVICE,
                 service_bits(32'd0, 1'b0, 32'd120006, 1'b1, 1'b1, HTTP_NOT_FOUND,
                              1'b1, 1'b1));

    // Zero cooldown: every attempt is due, even at the same tick.
    write_cooldown(32'd0);
    send_request(CMD_NUDGE, nudge_bits(32'hFFFF_FFFF, 16'd7, 32'hFFFF_FFFE));
    send_request(CMD_SERVICE,
                 service_bits(32'hFFFF_FFFE, 1'b0, 32'd120006, 1'b1, 1'b0, 10'd0,
                              1'b1, 1'b1));
    send_request(CMD_SERVICE,
                 service_bits(32'hFFFF_FFFE, 1'b0, 32'd120006, 1'b1, 1'b1, HTTP_UNAUTH,
                              1'b1, 1'b1));
    send_request(CMD_NUDGE, nudge_bits(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));

    // Random part, one phase per cooldown setting.
    tick = 32'd120006;
    for (int p = 0; p < 4; p++) begin
      write_cooldown(phase_cooldown[p]);
      phase_goal = items_sent + PHASE_ITEMS;
      while (items_sent < phase_goal) begin
        random_episode();
      end
    end

    // Let every awaited result come out, then give the verdict.
    in_tvalid <= 1'b0;
    do @(posedge clk); while (awaited != 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_update_fetch_retry_scheduler: clean");
    end else begin
      $display("tb_update_fetch_retry_scheduler: errors");
    end
    $finish;
  end

endmodule
